/* rtl/core/thb_pkg.sv */
// ----------------------------------------------------------------------------
// thb_pkg
// Shared types and constants for the triple buffer handoff block.
// ----------------------------------------------------------------------------
`default_nettype none

package thb_pkg;

  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] EMPTY_SLOT = 3'd7;

  typedef enum logic [1:0] {
    REQ_ACQ_WRITE = 2'd0,
    REQ_PUBLISH   = 2'd1,
    REQ_ACQ_READY = 2'd2,
    REQ_RELEASE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OWN_FREE       = 2'd0,
    OWN_WRITING    = 2'd1,
    OWN_READY      = 2'd2,
    OWN_DISPLAYING = 2'd3
  } owner_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // apply the captured request and register its result
  } thb_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/triple_buffer_handoff.sv */
// ----------------------------------------------------------------------------
// triple_buffer_handoff
// Frame buffer pool arbiter between a producer and a display consumer.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the request kind
// (acquire write, publish, acquire ready, release), tdata the buffer index
// used by publish and release. Each request yields exactly one result
// transaction on m_axis with ok, granted index, dropped flag and dropped
// index.
// An accepted request is captured in the load step and applied in the
// execute step of the controller, which registers its result and marks
// it valid. No new request is taken during the execute step. A new
// request is taken while the previous result is being taken in the same
// cycle.
// When the receiver stalls, the result is held in the output register and
// tready stays low, so the next request waits at the sender.
// Reset marks every buffer free and empties both ready slots and the
// shown index; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_buffer_handoff
  import thb_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 3
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // [2:0] buf_index, [7:3] zero
  input  wire logic [1:0] s_axis_tuser_i,  // [1:0] req_type
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o   // [0] ok, [3:1] granted_index,
                                           // [4] dropped, [7:5] dropped_index
);

  thb_cmd_t         cmd;
  logic             ok;
  logic [IDX_W-1:0] granted_index;
  logic             dropped;
  logic [IDX_W-1:0] dropped_index;

  thb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  thb_dp #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (s_axis_tuser_i),
    .buf_index_i     (s_axis_tdata_i[IDX_W-1:0]),
    .ok_o            (ok),
    .granted_index_o (granted_index),
    .dropped_o       (dropped),
    .dropped_index_o (dropped_index)
  );

  assign m_axis_tdata_o = {dropped_index, dropped, granted_index, ok};

endmodule

`default_nettype wire

/* rtl/core/thb_ctrl.sv */
// ----------------------------------------------------------------------------
// thb_ctrl
// Sequencer: accepts a request, runs it through the datapath, holds the
// result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module thb_ctrl
  import thb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output thb_cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  // Take a new request when idle and the output register is empty or draining now
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o = '{load: in_fire, exec: (state_q == ST_EXEC)};

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_fire_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted request did not enter execution");

  a_exec_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> out_valid_q)
    else $error("executed request produced no result");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EXEC))
    else $error("result appeared without an executed request");

endmodule

`default_nettype wire

/* rtl/core/thb_dp.sv */
// ----------------------------------------------------------------------------
// thb_dp
// Datapath: buffer ownership table, ready slots, shown index and the
// registered result of the last executed request.
// ----------------------------------------------------------------------------
`default_nettype none

module thb_dp
  import thb_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire thb_cmd_t         cmd_i,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [IDX_W-1:0] buf_index_i,
  output logic                  ok_o,
  output logic [IDX_W-1:0]      granted_index_o,
  output logic                  dropped_o,
  output logic [IDX_W-1:0]      dropped_index_o
);

  localparam logic [IDX_W-1:0] NumBuf = IDX_W'(NUM_BUFFERS);

  // captured request
  req_e             req_q;
  logic [IDX_W-1:0] idx_q;

  owner_e           owner_q [NUM_BUFFERS];
  owner_e           owner_d [NUM_BUFFERS];
  logic [IDX_W-1:0] newest_q, newest_d;
  logic [IDX_W-1:0] older_q, older_d;
  logic [IDX_W-1:0] shown_q, shown_d;

  logic             ok_q, ok_d;
  logic [IDX_W-1:0] granted_q, granted_d;
  logic             drop_q, drop_d;
  logic [IDX_W-1:0] drop_idx_q, drop_idx_d;

  // two write ports into the owner table, never aimed at the same entry
  logic             set_en;
  logic [IDX_W-1:0] set_idx;
  owner_e           set_val;
  logic             free_en;
  logic [IDX_W-1:0] free_idx;

  logic             free_found;
  logic [IDX_W-1:0] free_first;
  logic [IDX_W-1:0] take;

  function automatic logic slot_ok(logic [IDX_W-1:0] v);
    return v < NumBuf;
  endfunction

  // lowest free buffer
  always_comb begin
    free_found = 1'b0;
    free_first = EMPTY_SLOT;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (!free_found && owner_q[i] == OWN_FREE) begin
        free_found = 1'b1;
        free_first = IDX_W'(i);
      end
    end
  end

  always_comb begin
    newest_d   = newest_q;
    older_d    = older_q;
    shown_d    = shown_q;
    ok_d       = 1'b0;
    granted_d  = EMPTY_SLOT;
    drop_d     = 1'b0;
    drop_idx_d = EMPTY_SLOT;
    set_en     = 1'b0;
    set_idx    = idx_q;
    set_val    = OWN_FREE;
    free_en    = 1'b0;
    free_idx   = older_q;
    take       = EMPTY_SLOT;
    case (req_q)
      REQ_ACQ_WRITE: begin
        if (free_found) begin
          set_en    = 1'b1;
          set_idx   = free_first;
          set_val   = OWN_WRITING;
          ok_d      = 1'b1;
          granted_d = free_first;
        end else begin
          // recycle the older ready frame first, then the newest
          if (slot_ok(older_q)) begin
            take    = older_q;
            older_d = EMPTY_SLOT;
          end else if (slot_ok(newest_q)) begin
            take     = newest_q;
            newest_d = EMPTY_SLOT;
          end
          if (slot_ok(take)) begin
            set_en     = 1'b1;
            set_idx    = take;
            set_val    = OWN_WRITING;
            ok_d       = 1'b1;
            granted_d  = take;
            drop_d     = 1'b1;
            drop_idx_d = take;
          end
        end
      end
      REQ_PUBLISH: begin
        if (slot_ok(idx_q)) begin
          set_en   = 1'b1;
          set_idx  = idx_q;
          set_val  = OWN_READY;
          newest_d = idx_q;
          older_d  = newest_q;
          ok_d     = 1'b1;
          if (slot_ok(older_q) && older_q != idx_q) begin
            free_en    = 1'b1;
            free_idx   = older_q;
            drop_d     = 1'b1;
            drop_idx_d = older_q;
          end
        end
      end
      REQ_ACQ_READY: begin
        if (slot_ok(newest_q)) begin
          newest_d  = EMPTY_SLOT;
          older_d   = EMPTY_SLOT;
          set_en    = 1'b1;
          set_idx   = newest_q;
          set_val   = OWN_DISPLAYING;
          shown_d   = newest_q;
          ok_d      = 1'b1;
          granted_d = newest_q;
          if (slot_ok(older_q) && older_q != newest_q) begin
            free_en    = 1'b1;
            free_idx   = older_q;
            drop_d     = 1'b1;
            drop_idx_d = older_q;
          end
        end
      end
      REQ_RELEASE: begin
        if (slot_ok(idx_q)) begin
          if (shown_q == idx_q) begin
            shown_d = EMPTY_SLOT;
          end
          set_en  = 1'b1;
          set_idx = idx_q;
          set_val = OWN_FREE;
          ok_d    = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      owner_d[i] = owner_q[i];
      if (free_en && free_idx == IDX_W'(i)) begin
        owner_d[i] = OWN_FREE;
      end
      if (set_en && set_idx == IDX_W'(i)) begin
        owner_d[i] = set_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      idx_q <= buf_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        owner_q[i] <= OWN_FREE;
      end
      newest_q   <= EMPTY_SLOT;
      older_q    <= EMPTY_SLOT;
      shown_q    <= EMPTY_SLOT;
      ok_q       <= 1'b0;
      granted_q  <= EMPTY_SLOT;
      drop_q     <= 1'b0;
      drop_idx_q <= EMPTY_SLOT;
    end else if (cmd_i.exec) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        owner_q[i] <= owner_d[i];
      end
      newest_q   <= newest_d;
      older_q    <= older_d;
      shown_q    <= shown_d;
      ok_q       <= ok_d;
      granted_q  <= granted_d;
      drop_q     <= drop_d;
      drop_idx_q <= drop_idx_d;
    end
  end

  assign ok_o            = ok_q;
  assign granted_index_o = granted_q;
  assign dropped_o       = drop_q;
  assign dropped_index_o = drop_idx_q;

  a_drop_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> ok_q)
    else $error("frame dropped by a refused request");

  a_drop_idx_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drop_q |-> (drop_idx_q == EMPTY_SLOT))
    else $error("dropped index set without a drop");

  a_grant_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (granted_q != EMPTY_SLOT) |-> (ok_q && granted_q < NumBuf))
    else $error("granted buffer outside the pool");

endmodule

`default_nettype wire
